// ===== design/lpg_pkg.sv =====
package lpg_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int DELTA_W     = COORD_WIDTH + 1;
   localparam int ERR_W       = COORD_WIDTH + 3;
   localparam int ADDR_W      = 64;
   localparam int COLOR_W     = 32;
   localparam int PITCH_W     = 18;
   localparam int BPP_W       = 6;
   localparam int DIM_W       = 15;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 64;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int REQ_DATA_W = ((4 * COORD_WIDTH + COLOR_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((2 * COORD_WIDTH + ADDR_W + COLOR_W + 7) / 8) * 8;

   localparam int YOFF_W  = COORD_WIDTH + PITCH_W + 1;
   localparam int XPROD_W = COORD_WIDTH + BPP_W + 1;
   localparam int XOFF_W  = XPROD_W - 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FB_BASE   = 3'd0,
      CSR_FB_PITCH  = 3'd1,
      CSR_FB_BPP    = 3'd2,
      CSR_FB_WIDTH  = 3'd3,
      CSR_FB_HEIGHT = 3'd4
   } csr_index_type;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_STEP = 1'b1
   } opcode_type;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef struct packed {
      logic               is_load;
      logic               steep;
      coord_type          major_pos;
      coord_type          major_final;
      coord_type          minor_pos;
      logic               minor_neg;
      logic [DELTA_W-1:0] major_delta;
      logic [DELTA_W-1:0] minor_delta;
      logic [COLOR_W-1:0] color;
   } cmd_type;

   typedef struct packed {
      coord_type          px;
      coord_type          py;
      logic [COLOR_W-1:0] color;
      logic               last;
   } pix_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  base;
      logic [PITCH_W-1:0] pitch;
      logic [BPP_W-1:0]   bpp;
      logic [DIM_W-1:0]   width;
      logic [DIM_W-1:0]   height;
   } fb_type;

endpackage

// ===== design/lpg_front.sv =====
module lpg_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [lpg_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                          req_tuser,
   output logic                          push_valid,
   input  logic                          push_ready,
   output lpg_pkg::cmd_type              push_cmd
);
   import lpg_pkg::*;

   logic               a_valid_ff;
   logic               a_load_ff;
   coord_type          x0_ff, y0_ff, x1_ff, y1_ff;
   logic [DELTA_W-1:0] adx_ff, ady_ff;
   logic               xgt_ff, ygt_ff;
   logic [COLOR_W-1:0] color_ff;

   coord_type              x0_in, y0_in, x1_in, y1_in;
   logic signed [DELTA_W-1:0] x0e, y0e, x1e, y1e;
   logic                   xgt_in, ygt_in;
   logic [DELTA_W-1:0]     adx_in, ady_in;
   logic                   req_take;

   logic steep;
   logic swap;

   assign x0_in = req_tdata[COORD_WIDTH-1:0];
   assign y0_in = req_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
   assign x1_in = req_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];
   assign y1_in = req_tdata[4*COORD_WIDTH-1:3*COORD_WIDTH];

   assign x0e = {x0_in[COORD_WIDTH-1], x0_in};
   assign y0e = {y0_in[COORD_WIDTH-1], y0_in};
   assign x1e = {x1_in[COORD_WIDTH-1], x1_in};
   assign y1e = {y1_in[COORD_WIDTH-1], y1_in};

   assign xgt_in = x0e > x1e;
   assign ygt_in = y0e > y1e;
   assign adx_in = xgt_in ? DELTA_W'(x0e - x1e) : DELTA_W'(x1e - x0e);
   assign ady_in = ygt_in ? DELTA_W'(y0e - y1e) : DELTA_W'(y1e - y0e);

   assign req_tready = !a_valid_ff || push_ready;
   assign req_take   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_tready) begin
         a_valid_ff <= req_tvalid;
      end
      if (req_take) begin
         a_load_ff <= (opcode_type'(req_tuser) == OP_LOAD);
         x0_ff     <= x0_in;
         y0_ff     <= y0_in;
         x1_ff     <= x1_in;
         y1_ff     <= y1_in;
         adx_ff    <= adx_in;
         ady_ff    <= ady_in;
         xgt_ff    <= xgt_in;
         ygt_ff    <= ygt_in;
         color_ff  <= req_tdata[4*COORD_WIDTH+COLOR_W-1:4*COORD_WIDTH];
      end
   end

   // ties go to the steep handler
   assign steep = !(ady_ff < adx_ff);
   assign swap  = steep ? ygt_ff : xgt_ff;

   assign push_valid = a_valid_ff;

   always_comb begin
      push_cmd.is_load     = a_load_ff;
      push_cmd.steep       = steep;
      push_cmd.color       = color_ff;
      push_cmd.major_delta = steep ? ady_ff : adx_ff;
      push_cmd.minor_delta = steep ? adx_ff : ady_ff;
      push_cmd.minor_neg   = (push_cmd.minor_delta != '0) && (xgt_ff ^ ygt_ff);
      if (steep) begin
         push_cmd.major_pos   = swap ? y1_ff : y0_ff;
         push_cmd.major_final = swap ? y0_ff : y1_ff;
         push_cmd.minor_pos   = swap ? x1_ff : x0_ff;
      end else begin
         push_cmd.major_pos   = swap ? x1_ff : x0_ff;
         push_cmd.major_final = swap ? x0_ff : x1_ff;
         push_cmd.minor_pos   = swap ? y1_ff : y0_ff;
      end
   end

endmodule

// ===== design/lpg_queue.sv =====
module lpg_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  lpg_pkg::cmd_type push_cmd,
   output logic             pop_valid,
   input  logic             pop_ready,
   output lpg_pkg::cmd_type pop_cmd
);
   import lpg_pkg::*;

   cmd_type             store_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;
   logic [QPTR_W-1:0]   wr_ptr_in, rd_ptr_in;
   logic [QCNT_W-1:0]   count_in;
   logic                do_push, do_pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = store_ff[rd_ptr_ff];

   assign do_push = push_valid && push_ready;
   assign do_pop  = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== design/lpg_back.sv =====
module lpg_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  lpg_pkg::cmd_type pop_cmd,
   output logic             pix_valid,
   input  logic             pix_ready,
   output lpg_pkg::pix_type pix
);
   import lpg_pkg::*;

   logic                     active_ff;
   logic                     steep_ff;
   coord_type                major_pos_ff, major_final_ff, minor_pos_ff;
   logic                     minor_neg_ff;
   logic signed [ERR_W-1:0]  err_ff, err_up_ff, err_dn_ff;
   logic [COLOR_W-1:0]       color_ff;

   logic signed [ERR_W-1:0]  major_e, minor_e;
   logic                     is_last;
   logic                     load_fire, step_fire;

   assign major_e = $signed(ERR_W'(pop_cmd.major_delta));
   assign minor_e = $signed(ERR_W'(pop_cmd.minor_delta));

   assign is_last = $signed(major_pos_ff) >= $signed(major_final_ff);

   assign pix_valid = pop_valid && !pop_cmd.is_load && active_ff;
   assign pop_ready = pop_cmd.is_load || !active_ff || pix_ready;
   assign load_fire = pop_valid && pop_cmd.is_load;
   assign step_fire = pix_valid && pix_ready;

   always_comb begin
      pix.px    = steep_ff ? minor_pos_ff : major_pos_ff;
      pix.py    = steep_ff ? major_pos_ff : minor_pos_ff;
      pix.color = color_ff;
      pix.last  = is_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (load_fire) begin
         active_ff <= 1'b1;
      end else if (step_fire && is_last) begin
         active_ff <= 1'b0;
      end

      if (load_fire) begin
         steep_ff       <= pop_cmd.steep;
         major_pos_ff   <= pop_cmd.major_pos;
         major_final_ff <= pop_cmd.major_final;
         minor_pos_ff   <= pop_cmd.minor_pos;
         minor_neg_ff   <= pop_cmd.minor_neg;
         color_ff       <= pop_cmd.color;
         err_ff         <= (minor_e <<< 1) - major_e;
         err_up_ff      <= (minor_e - major_e) <<< 1;
         err_dn_ff      <= minor_e <<< 1;
      end else if (step_fire) begin
         if (err_ff > 0) begin
            minor_pos_ff <= minor_neg_ff ? minor_pos_ff - 1'b1 : minor_pos_ff + 1'b1;
            err_ff       <= err_ff + err_up_ff;
         end else begin
            err_ff       <= err_ff + err_dn_ff;
         end
         if (!is_last) begin
            major_pos_ff <= major_pos_ff + 1'b1;
         end
      end
   end

endmodule

// ===== design/lpg_addr.sv =====
module lpg_addr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  lpg_pkg::pix_type               pix,
   input  lpg_pkg::fb_type                fb,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [lpg_pkg::RSP_DATA_W-1:0] rsp_tdata,   // pixel_x, pixel_y, pixel_address, pixel_color
   output logic                           rsp_tuser,   // visible
   output logic                           rsp_tlast
);
   import lpg_pkg::*;

   logic                       s1_valid_ff;
   logic signed [YOFF_W-1:0]   s1_yoff_ff;
   logic signed [XPROD_W-1:0]  s1_xprod_ff;
   logic                       s1_vis_ff;
   pix_type                    s1_pix_ff;

   logic                       s2_valid_ff;
   logic [ADDR_W-1:0]          s2_part_ff;
   logic signed [XOFF_W-1:0]   s2_xoff_ff;
   logic                       s2_vis_ff;
   pix_type                    s2_pix_ff;

   logic                       o_valid_ff;
   logic [ADDR_W-1:0]          o_addr_ff;
   logic                       o_vis_ff;
   pix_type                    o_pix_ff;

   logic signed [YOFF_W-1:0]   yoff_in;
   logic signed [XPROD_W-1:0]  xprod_in;
   logic                       vis_in;
   logic                       o_ready, s2_ready;

   assign o_ready  = !o_valid_ff || rsp_tready;
   assign s2_ready = !s2_valid_ff || o_ready;
   assign in_ready = !s1_valid_ff || s2_ready;

   assign yoff_in  = $signed(pix.py) * $signed({1'b0, fb.pitch});
   assign xprod_in = $signed(pix.px) * $signed({1'b0, fb.bpp});
   assign vis_in   = !pix.px[COORD_WIDTH-1] && !pix.py[COORD_WIDTH-1]
                     && ({{DIM_W{1'b0}}, pix.px} < {{COORD_WIDTH{1'b0}}, fb.width})
                     && ({{DIM_W{1'b0}}, pix.py} < {{COORD_WIDTH{1'b0}}, fb.height});

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         o_valid_ff  <= 1'b0;
      end else begin
         if (in_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (o_ready) begin
            o_valid_ff <= s2_valid_ff;
         end
      end

      if (in_ready && in_valid) begin
         s1_yoff_ff  <= yoff_in;
         s1_xprod_ff <= xprod_in;
         s1_vis_ff   <= vis_in;
         s1_pix_ff   <= pix;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_part_ff <= fb.base + {{(ADDR_W-YOFF_W){s1_yoff_ff[YOFF_W-1]}}, s1_yoff_ff};
         // floor of x*bpp/8
         s2_xoff_ff <= s1_xprod_ff[XPROD_W-1:3];
         s2_vis_ff  <= s1_vis_ff;
         s2_pix_ff  <= s1_pix_ff;
      end
      if (o_ready && s2_valid_ff) begin
         o_addr_ff <= s2_part_ff + {{(ADDR_W-XOFF_W){s2_xoff_ff[XOFF_W-1]}}, s2_xoff_ff};
         o_vis_ff  <= s2_vis_ff;
         o_pix_ff  <= s2_pix_ff;
      end
   end

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({o_pix_ff.color, o_addr_ff, o_pix_ff.py, o_pix_ff.px});
   assign rsp_tuser  = o_vis_ff;
   assign rsp_tlast  = o_pix_ff.last;

endmodule

// ===== design/line_pixel_generator.sv =====
// Bresenham line rasterizer with framebuffer clipping and byte address output. A load item
// (tuser 0) sets up a line from two endpoints and a color and returns nothing; each step item
// (tuser 1) returns the next pixel with its address base + y*pitch + floor(x*bpp/8), a visible
// flag in tuser and the final pixel marked by tlast; a step with no line loaded returns nothing.
// Items pass a register stage that classifies the line, then a four-entry queue, then the
// stepping engine and a three-stage address pipeline (multiply, add row offset, add column
// offset). One item is taken per clock and one pixel leaves per clock when both sides are
// free; a pixel passes the front register, the queue and the three address stages. Framebuffer
// registers are written through the csr port and are used by the address pipeline as soon as
// written; write them only while no items are in flight.
module line_pixel_generator (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [lpg_pkg::REQ_DATA_W-1:0] req_tdata,   // start_x, start_y, end_x, end_y, draw_color
   input  logic                           req_tuser,   // opcode
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [lpg_pkg::RSP_DATA_W-1:0] rsp_tdata,   // pixel_x, pixel_y, pixel_address, pixel_color
   output logic                           rsp_tuser,   // visible
   output logic                           rsp_tlast,   // last_pixel
   input  logic                           csr_wr_en,
   input  logic [lpg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lpg_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lpg_pkg::*;

   fb_type  fb_ff;

   logic    push_valid, push_ready;
   cmd_type push_cmd;
   logic    pop_valid, pop_ready;
   cmd_type pop_cmd;
   logic    pix_valid, pix_ready;
   pix_type pix;

   always_ff @(posedge clock) begin
      if (reset) begin
         fb_ff.base   <= '0;
         fb_ff.pitch  <= PITCH_W'(2560);
         fb_ff.bpp    <= BPP_W'(32);
         fb_ff.width  <= DIM_W'(640);
         fb_ff.height <= DIM_W'(480);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FB_BASE:   fb_ff.base   <= csr_wdata[ADDR_W-1:0];
            CSR_FB_PITCH:  fb_ff.pitch  <= csr_wdata[PITCH_W-1:0];
            CSR_FB_BPP:    fb_ff.bpp    <= csr_wdata[BPP_W-1:0];
            CSR_FB_WIDTH:  fb_ff.width  <= csr_wdata[DIM_W-1:0];
            CSR_FB_HEIGHT: fb_ff.height <= csr_wdata[DIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   lpg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   lpg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   lpg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd),
      .pix_valid (pix_valid),
      .pix_ready (pix_ready),
      .pix       (pix)
   );

   lpg_addr u_addr (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (pix_valid),
      .in_ready   (pix_ready),
      .pix        (pix),
      .fb         (fb_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
